FILE: rtl/core/msdc_pkg.sv
// Shared types and constants for the maximum subarray search block.
package msdc_pkg;

	localparam int SUM_OUT_W = 42;
	localparam int IDX_W = 11;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_INIT,
		ST_TOP,
		ST_LEAF,
		ST_XL,
		ST_XR,
		ST_POPR,
		ST_POPL,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PH_LEFT,
		PH_RIGHT,
		PH_CROSS
	} phase_t;

	typedef enum logic [1:0] {
		TK_LEAF,
		TK_LEFT,
		TK_RIGHT,
		TK_CROSS
	} top_kind_t;

	typedef struct packed {
		logic load;
		logic init;
		logic step;
		logic leaf;
		logic x_left;
		logic x_right;
		logic pop_r;
		logic pop_l;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic      last_beat;
		logic      frames_empty;
		top_kind_t kind;
		logic      at_lo;
		logic      at_hi;
		logic      out_free;
	} sts_t;

endpackage

FILE: rtl/core/msdc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module msdc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/core/msdc_ctrl.sv
// Sequencer for loading, the stack-driven recursive search and result hand-off.
module msdc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  msdc_pkg::sts_t sts,
	output msdc_pkg::cmd_t cmd
);

	msdc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msdc_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			msdc_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
				if (sts.last_beat) begin
					state_d = msdc_pkg::ST_INIT;
				end
			end
			msdc_pkg::ST_INIT: begin
				cmd.init = 1'b1;
				state_d = msdc_pkg::ST_TOP;
			end
			msdc_pkg::ST_TOP: begin
				if (sts.frames_empty) begin
					state_d = msdc_pkg::ST_EMIT;
				end else begin
					cmd.step = 1'b1;
					unique case (sts.kind)
						msdc_pkg::TK_LEAF:  state_d = msdc_pkg::ST_LEAF;
						msdc_pkg::TK_CROSS: state_d = msdc_pkg::ST_XL;
						default:            state_d = msdc_pkg::ST_TOP;
					endcase
				end
			end
			msdc_pkg::ST_LEAF: begin
				cmd.leaf = 1'b1;
				state_d = msdc_pkg::ST_TOP;
			end
			msdc_pkg::ST_XL: begin
				cmd.x_left = 1'b1;
				if (sts.at_lo) begin
					state_d = msdc_pkg::ST_XR;
				end
			end
			msdc_pkg::ST_XR: begin
				cmd.x_right = 1'b1;
				if (sts.at_hi) begin
					state_d = msdc_pkg::ST_POPR;
				end
			end
			msdc_pkg::ST_POPR: begin
				cmd.pop_r = 1'b1;
				state_d = msdc_pkg::ST_POPL;
			end
			msdc_pkg::ST_POPL: begin
				cmd.pop_l = 1'b1;
				state_d = msdc_pkg::ST_TOP;
			end
			msdc_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = msdc_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = msdc_pkg::ST_LOAD;
			end
		endcase
	end

endmodule

FILE: rtl/core/msdc_dp.sv
// Datapath: sample store, frame and result stacks, crossing scan, output register.
module msdc_dp #(
	parameter int MAX_ITEMS = 1024,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  msdc_pkg::cmd_t                       cmd,
	output msdc_pkg::sts_t                       sts,
	input  logic                                 in_valid,
	input  logic signed [SAMPLE_WIDTH-1:0]       value,
	input  logic                                 is_last,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [msdc_pkg::SUM_OUT_W-1:0] best_sum,
	output logic [msdc_pkg::IDX_W-1:0]           first_index,
	output logic [msdc_pkg::IDX_W-1:0]           end_index,
	output logic                                 overflow
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int DEPTH = AW + 1;
	localparam int FIW = $clog2(DEPTH);
	localparam int FPW = $clog2(DEPTH + 1);
	localparam int SW = SAMPLE_WIDTH + AW + 1;

	// load counter and overflow
	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic          beat;
	logic          room;

	// frame stack
	logic [AW-1:0]     fs_lo_q [DEPTH];
	logic [AW-1:0]     fs_hi_q [DEPTH];
	msdc_pkg::phase_t  fs_ph_q [DEPTH];
	logic [FPW-1:0]    fp_q;
	logic [FPW-1:0]    fp_m1;
	logic [FIW-1:0]    ftop;
	logic [FIW-1:0]    fpush;
	logic [AW-1:0]     top_lo, top_hi, mid, mid_p1;
	logic [AW:0]       mid_sum;
	msdc_pkg::phase_t  top_ph;
	logic [CW-1:0]     cnt_m1;

	// result stack
	logic signed [SW-1:0] rs_sum_q [DEPTH];
	logic [AW-1:0]        rs_first_q [DEPTH];
	logic [AW-1:0]        rs_last_q [DEPTH];
	logic [FPW-1:0]       rp_q;
	logic [FPW-1:0]       rp_m1;
	logic [FIW-1:0]       rtop;
	logic [FIW-1:0]       rpush;

	// crossing scan
	logic [AW-1:0]        pos_q;
	logic signed [SW-1:0] acc_q, best_q, bl_q;
	logic                 seen_q;
	logic [AW-1:0]        xf_q, xl_q;
	logic signed [SW-1:0] acc_n;
	logic                 take;

	// popped right half and crossing run
	logic signed [SW-1:0] r_sum_q, c_sum_q;
	logic [AW-1:0]        r_first_q, r_last_q;

	logic signed [SW-1:0] w_sum;
	logic [AW-1:0]        w_first, w_last;

	logic [AW-1:0]             raddr;
	logic [SAMPLE_WIDTH-1:0]   rdata;
	logic signed [SW-1:0]      rd_wide;
	logic [AW:0]               first_p1, last_p1;
	logic                      out_valid_q;

	assign beat = cmd.load & in_valid;
	assign room = (cnt_q < CW'(MAX_ITEMS));

	msdc_ram #(
		.WIDTH(SAMPLE_WIDTH),
		.DEPTH(MAX_ITEMS)
	) u_samples (
		.clk  (clk),
		.we   (beat & room),
		.waddr(cnt_q[AW-1:0]),
		.wdata(value),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_wide = SW'($signed(rdata));

	assign fp_m1  = fp_q - FPW'(1);
	assign ftop   = fp_m1[FIW-1:0];
	assign fpush  = fp_q[FIW-1:0];
	assign top_lo = fs_lo_q[ftop];
	assign top_hi = fs_hi_q[ftop];
	assign top_ph = fs_ph_q[ftop];
	assign mid_sum = {1'b0, top_lo} + {1'b0, top_hi};
	assign mid    = mid_sum[AW:1];
	assign mid_p1 = mid + AW'(1);
	assign cnt_m1 = cnt_q - CW'(1);

	assign rp_m1 = rp_q - FPW'(1);
	assign rtop  = rp_m1[FIW-1:0];
	assign rpush = rp_q[FIW-1:0];

	assign acc_n = acc_q + rd_wide;
	assign take  = !seen_q || (acc_n >= best_q);

	// sample read address: one element per cycle during the scans
	always_comb begin
		raddr = pos_q;
		if (cmd.step) begin
			raddr = (top_lo == top_hi) ? top_lo : mid;
		end else if (cmd.x_left) begin
			raddr = (pos_q == top_lo) ? mid_p1 : pos_q - AW'(1);
		end else if (cmd.x_right) begin
			raddr = pos_q + AW'(1);
		end
	end

	// left half wins ties, then right half, then crossing run
	always_comb begin
		if (rs_sum_q[rtop] >= r_sum_q && rs_sum_q[rtop] >= c_sum_q) begin
			w_sum   = rs_sum_q[rtop];
			w_first = rs_first_q[rtop];
			w_last  = rs_last_q[rtop];
		end else if (r_sum_q >= c_sum_q) begin
			w_sum   = r_sum_q;
			w_first = r_first_q;
			w_last  = r_last_q;
		end else begin
			w_sum   = c_sum_q;
			w_first = xf_q;
			w_last  = xl_q;
		end
	end

	always_comb begin
		sts.last_beat    = beat & is_last;
		sts.frames_empty = (fp_q == '0);
		sts.at_lo        = (pos_q == top_lo);
		sts.at_hi        = (pos_q == top_hi);
		sts.out_free     = !out_valid_q || !out_stall;
		if (top_lo == top_hi) begin
			sts.kind = msdc_pkg::TK_LEAF;
		end else begin
			unique case (top_ph)
				msdc_pkg::PH_LEFT:  sts.kind = msdc_pkg::TK_LEFT;
				msdc_pkg::PH_RIGHT: sts.kind = msdc_pkg::TK_RIGHT;
				default:            sts.kind = msdc_pkg::TK_CROSS;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			fp_q        <= '0;
			rp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (beat) begin
				if (room) begin
					cnt_q <= cnt_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.init) begin
				fp_q <= FPW'(1);
				rp_q <= '0;
			end
			if (cmd.step && top_lo != top_hi &&
				(top_ph == msdc_pkg::PH_LEFT || top_ph == msdc_pkg::PH_RIGHT)) begin
				fp_q <= fp_q + FPW'(1);
			end
			if (cmd.leaf) begin
				fp_q <= fp_m1;
				rp_q <= rp_q + FPW'(1);
			end
			if (cmd.pop_r) begin
				rp_q <= rp_m1;
			end
			if (cmd.pop_l) begin
				fp_q <= fp_m1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				cnt_q       <= '0;
				ovf_q       <= 1'b0;
				rp_q        <= '0;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// stacks, scan registers and output payload
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			fs_lo_q[0] <= '0;
			fs_hi_q[0] <= cnt_m1[AW-1:0];
			fs_ph_q[0] <= msdc_pkg::PH_LEFT;
		end
		if (cmd.step && top_lo != top_hi) begin
			unique case (top_ph)
				msdc_pkg::PH_LEFT: begin
					fs_ph_q[ftop]  <= msdc_pkg::PH_RIGHT;
					fs_lo_q[fpush] <= top_lo;
					fs_hi_q[fpush] <= mid;
					fs_ph_q[fpush] <= msdc_pkg::PH_LEFT;
				end
				msdc_pkg::PH_RIGHT: begin
					fs_ph_q[ftop]  <= msdc_pkg::PH_CROSS;
					fs_lo_q[fpush] <= mid_p1;
					fs_hi_q[fpush] <= top_hi;
					fs_ph_q[fpush] <= msdc_pkg::PH_LEFT;
				end
				default: begin
					pos_q  <= mid;
					acc_q  <= '0;
					seen_q <= 1'b0;
				end
			endcase
		end
		if (cmd.leaf) begin
			rs_sum_q[rpush]   <= rd_wide;
			rs_first_q[rpush] <= top_lo;
			rs_last_q[rpush]  <= top_lo;
		end
		if (cmd.x_left) begin
			if (take) begin
				best_q <= acc_n;
				xf_q   <= pos_q;
			end
			if (pos_q == top_lo) begin
				bl_q   <= take ? acc_n : best_q;
				pos_q  <= mid_p1;
				acc_q  <= '0;
				seen_q <= 1'b0;
			end else begin
				pos_q  <= pos_q - AW'(1);
				acc_q  <= acc_n;
				seen_q <= 1'b1;
			end
		end
		if (cmd.x_right) begin
			if (take) begin
				best_q <= acc_n;
				xl_q   <= pos_q;
			end
			pos_q  <= pos_q + AW'(1);
			acc_q  <= acc_n;
			seen_q <= 1'b1;
		end
		if (cmd.pop_r) begin
			r_sum_q   <= rs_sum_q[rtop];
			r_first_q <= rs_first_q[rtop];
			r_last_q  <= rs_last_q[rtop];
			c_sum_q   <= bl_q + best_q;
		end
		if (cmd.pop_l) begin
			rs_sum_q[rtop]   <= w_sum;
			rs_first_q[rtop] <= w_first;
			rs_last_q[rtop]  <= w_last;
		end
		if (cmd.emit) begin
			best_sum    <= msdc_pkg::SUM_OUT_W'(rs_sum_q[rtop]);
			first_index <= msdc_pkg::IDX_W'(first_p1);
			end_index   <= msdc_pkg::IDX_W'(last_p1);
			overflow    <= ovf_q;
		end
	end

	assign first_p1  = {1'b0, rs_first_q[rtop]} + (AW + 1)'(1);
	assign last_p1   = {1'b0, rs_last_q[rtop]} + (AW + 1)'(1);
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_frame_depth: assert property (@(posedge clk) disable iff (!arst_n)
		fp_q <= FPW'(DEPTH))
		else $error("frame stack overrun");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> rp_q == FPW'(1))
		else $error("search did not leave exactly one result");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.x_left |-> (pos_q >= top_lo && pos_q <= mid))
		else $error("left scan outside its range");

	a_pop_pair: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_r |-> rp_q >= FPW'(2))
		else $error("merge with fewer than two results");
`endif

endmodule

FILE: rtl/core/max_subarray_divide_conquer.sv
// Top level of the maximum contiguous subarray search block.
// Input channel (in_valid/in_stall): one signed sample per beat in value; is_last
// closes the run and starts the search. Samples are stored in order; beats past
// MAX_ITEMS are dropped and reported through overflow on the run's result.
// Output channel (out_valid/out_stall): one beat per run carrying best_sum and
// the 1-based first_index and end_index of the best run.
// Loading takes every beat on which in_valid is high. The search is a post-order
// walk over a frame stack using one sample RAM read port; the crossing scans read
// one stored sample per cycle. in_stall stays high during the search.
// The result sits in an output register; if out_stall holds a previous result,
// the finished search waits in place until the register frees up.
// Reset clears counters, stacks pointers and out_valid; no clearing pass.
module max_subarray_divide_conquer #(
	parameter int MAX_ITEMS = 1024,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]       value,
	input  logic                                 is_last,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [msdc_pkg::SUM_OUT_W-1:0] best_sum,
	output logic [msdc_pkg::IDX_W-1:0]           first_index,
	output logic [msdc_pkg::IDX_W-1:0]           end_index,
	output logic                                 overflow
);

	msdc_pkg::cmd_t cmd;
	msdc_pkg::sts_t sts;

	msdc_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.sts   (sts),
		.cmd   (cmd)
	);

	msdc_dp #(
		.MAX_ITEMS   (MAX_ITEMS),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_valid   (in_valid),
		.value      (value),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.best_sum   (best_sum),
		.first_index(first_index),
		.end_index  (end_index),
		.overflow   (overflow)
	);

	assign in_stall = ~cmd.load;

endmodule

FILE: sim/tb_top.sv
// Testbench for the maximum contiguous subarray search block.
`timescale 1ns / 100ps

module tb_top;

	localparam int CAPACITY = 1024;
	localparam int N_ITEMS  = 1850;

	typedef struct {
		longint   sum;
		int       first;
		int       last;
	} span_t;

	typedef struct {
		logic signed [msdc_pkg::SUM_OUT_W-1:0] sum;
		logic [msdc_pkg::IDX_W-1:0]            first;
		logic [msdc_pkg::IDX_W-1:0]            last;
		logic                                  ovf;
	} answer_t;

	typedef struct {
		int     v;
		bit     last;
		bit     known;
		longint sum;
		int     fi;
		int     ei;
	} vector_t;

	logic                                  clk = 0;
	logic                                  arst_n = 0;
	logic                                  in_valid = 0;
	logic                                  in_stall;
	logic signed [31:0]                    value = '0;
	logic                                  is_last = 0;
	logic                                  out_valid;
	logic                                  out_stall = 0;
	logic signed [msdc_pkg::SUM_OUT_W-1:0] best_sum;
	logic [msdc_pkg::IDX_W-1:0]            first_index;
	logic [msdc_pkg::IDX_W-1:0]            end_index;
	logic                                  overflow;

	max_subarray_divide_conquer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .value(value), .is_last(is_last),
		.out_valid(out_valid), .out_stall(out_stall), .best_sum(best_sum),
		.first_index(first_index), .end_index(end_index), .overflow(overflow)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// predictor state
	longint  stored [CAPACITY];
	int      stored_cnt = 0;
	bit      dropped = 0;
	answer_t pending[$];
	int      errors = 0;
	bit      calm = 0;

	function automatic span_t best_span(int lo, int hi);
		span_t l, r, c;
		int mid;
		longint acc, bl, br;
		if (lo >= hi) begin
			l.sum = stored[lo]; l.first = lo; l.last = lo;
			return l;
		end
		mid = lo + (hi - lo) / 2;
		l = best_span(lo, mid);
		r = best_span(mid + 1, hi);
		// crossing run: ties keep leftmost start and rightmost end
		acc = 0; bl = 0;
		for (int i = mid; i >= lo; i--) begin
			acc += stored[i];
			if (i == mid || acc >= bl) begin
				bl = acc; c.first = i;
			end
		end
		acc = 0; br = 0;
		for (int i = mid + 1; i <= hi; i++) begin
			acc += stored[i];
			if (i == mid + 1 || acc >= br) begin
				br = acc; c.last = i;
			end
		end
		c.sum = bl + br;
		if (l.sum >= r.sum && l.sum >= c.sum) return l;
		if (r.sum >= l.sum && r.sum >= c.sum) return r;
		return c;
	endfunction

	// absorb one accepted beat; returns 1 with the answer when the run closes
	function automatic bit absorb_beat(logic signed [31:0] v, bit last, output answer_t a);
		span_t s;
		if (stored_cnt < CAPACITY) begin
			stored[stored_cnt] = longint'(v);
			stored_cnt++;
		end else
			dropped = 1;
		if (!last) return 0;
		s = best_span(0, stored_cnt - 1);
		a.sum = s.sum[msdc_pkg::SUM_OUT_W-1:0];
		a.first = msdc_pkg::IDX_W'(s.first + 1);
		a.last = msdc_pkg::IDX_W'(s.last + 1);
		a.ovf = dropped;
		stored_cnt = 0;
		dropped = 0;
		return 1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_beat(logic signed [31:0] v, bit last, bit known, answer_t fixed);
		int gap;
		answer_t a;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		value <= v;
		is_last <= last;
		do @(posedge clk); while (in_stall);
		if (absorb_beat(v, last, a))
			pending.push_back(known ? fixed : a);
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		answer_t e;
		if (out_valid && !out_stall) begin
			if (pending.size() == 0) begin
				report_mismatch("result beats", pending.size() + 1, pending.size());
			end else begin
				e = pending.pop_front();
				if (best_sum !== e.sum) report_mismatch("best_sum", best_sum, e.sum);
				if (first_index !== e.first)
					report_mismatch("first_index", first_index, e.first);
				if (end_index !== e.last) report_mismatch("end_index", end_index, e.last);
				if (overflow !== e.ovf) report_mismatch("overflow", overflow, e.ovf);
			end
		end
	end

	// receiver back-pressure
	int hold = 0;
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (hold > 0) begin
			hold <= hold - 1;
			out_stall <= 1;
		end else if (calm || r < 65) begin
			out_stall <= 0;
		end else begin
			out_stall <= 1;
			hold <= (r < 95) ? $urandom_range(0, 3) : $urandom_range(20, 80);
		end
	end

	function automatic logic signed [31:0] draw_value(int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(0, 100)) - 50;
			2: return 32'sh7fffffff;
			3: return 32'sh80000000;
			default: return $signed($urandom_range(0, 2)) - 1;
		endcase
	endfunction

	vector_t directed[] = '{
		'{32'h7fffffff, 1, 1, 64'sd2147483647, 1, 1},
		'{32'h80000000, 1, 1, -64'sd2147483648, 1, 1},
		'{-1, 0, 0, 0, 0, 0}, '{-1, 1, 1, -1, 1, 1},
		'{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0},
		'{0, 1, 1, 0, 1, 1},
		'{1, 0, 0, 0, 0, 0}, '{-1, 0, 0, 0, 0, 0}, '{1, 1, 0, 0, 0, 0},
		'{-5, 0, 0, 0, 0, 0}, '{3, 0, 0, 0, 0, 0}, '{4, 0, 0, 0, 0, 0},
		'{-9, 0, 0, 0, 0, 0}, '{6, 1, 0, 0, 0, 0},
		'{32'h7fffffff, 0, 0, 0, 0, 0}, '{32'h7fffffff, 1, 0, 0, 0, 0},
		'{32'h80000000, 0, 0, 0, 0, 0}, '{32'h7fffffff, 0, 0, 0, 0, 0},
		'{32'h80000000, 1, 0, 0, 0, 0}
	};

	initial begin
		answer_t fixed;
		int sent, len, mode, r;
		bit big_done;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (directed[i]) begin
			fixed.sum = directed[i].sum[msdc_pkg::SUM_OUT_W-1:0];
			fixed.first = msdc_pkg::IDX_W'(directed[i].fi);
			fixed.last = msdc_pkg::IDX_W'(directed[i].ei);
			fixed.ovf = 0;
			send_beat(directed[i].v, directed[i].last, directed[i].known, fixed);
		end

		sent = directed.size();
		big_done = 0;
		while (sent < N_ITEMS) begin
			r = $urandom_range(0, 99);
			if (!big_done && sent > 300) begin
				// run past capacity; the closing beat itself is dropped
				len = CAPACITY + $urandom_range(2, 6);
				big_done = 1;
			end else if (r < 75) len = $urandom_range(1, 8);
			else if (r < 97) len = $urandom_range(9, 64);
			else len = $urandom_range(65, 300);
			mode = $urandom_range(0, 9);
			if (mode > 4) mode = 0;
			calm = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < len; k++)
				send_beat(draw_value(mode), k == len - 1, 0, fixed);
			sent += len;
		end
		in_valid <= 0;
		calm = 0;

		while (pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("** max_subarray_divide_conquer: PASSED **");
		else
			$display("** max_subarray_divide_conquer: FAILED **");
		$finish;
	end

	initial begin
		#20ms;
		$display("** max_subarray_divide_conquer: FAILED **");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/msdc_pkg.sv
rtl/core/msdc_ram.sv
rtl/core/msdc_ctrl.sv
rtl/core/msdc_dp.sv
rtl/core/max_subarray_divide_conquer.sv
sim/tb_top.sv
